[rtl/core/vfc_pkg.sv]
// Package: shared constants, item kind codes and sequencer states for the frustum culler.
`default_nettype none
package vfc_pkg;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int NUM_PLANES        = 6;
    localparam int MATRIX_DEPTH      = 16;
    localparam int PLANE_W           = 128;

    localparam logic [2:0] KIND_WRITE  = 3'd0;
    localparam logic [2:0] KIND_APPLY  = 3'd1;
    localparam logic [2:0] KIND_POINT  = 3'd2;
    localparam logic [2:0] KIND_SPHERE = 3'd3;
    localparam logic [2:0] KIND_BOX    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MREAD,
        S_SQ,
        S_SQRT,
        S_DLOAD,
        S_DIV,
        S_DSTORE,
        S_PWRITE,
        S_TEST,
        S_RESP
    } t_state;
endpackage
`default_nettype wire

[rtl/core/vfc_if.sv]
// Interfaces: input item channel and result channel of the frustum culler.
`default_nettype none
interface vfc_in_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  kind;
    logic        [1:0]  matrix_col;
    logic        [1:0]  matrix_row;
    logic signed [31:0] matrix_value;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
    logic        [30:0] radius;

    modport source (output valid, kind, matrix_col, matrix_row, matrix_value,
                    px, py, pz, qx, qy, qz, radius, input ready);
    modport sink   (input valid, kind, matrix_col, matrix_row, matrix_value,
                    px, py, pz, qx, qy, qz, radius, output ready);
endinterface

interface vfc_out_if;
    logic        valid;
    logic        ready;
    logic        visible;
    logic [31:0] visible_total;
    logic [31:0] culled_total;

    modport source (output valid, visible, visible_total, culled_total, input ready);
    modport sink   (input valid, visible, visible_total, culled_total, output ready);
endinterface
`default_nettype wire

[rtl/core/vfc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module vfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/core/view_frustum_culler_core.sv]
// Top level: six-plane view frustum culler, memory-based plane store and sequencer.
`default_nettype none
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------------
//  i_in     | in  | valid/ready   | kind, matrix_col/row/value, px..pz, qx..qz, radius
//  o_out    | out | valid/ready   | visible, visible_total, culled_total
//
//  One item at a time. Matrix write and unused kinds: from idle the sequencer goes to
//  the result state, where the result register loads once the output register is free.
//  Point/sphere/box test: the plane RAM is read one plane per cycle into three
//  parallel multipliers, a sum and compare stage follows.
//  Apply: per plane 9 matrix RAM reads, 4 squares, 32 square-root steps and four
//  divides of 32+FRACTION_BITS steps each, plus one plane RAM write; six planes.
//  Synchronous active-low reset clears control, counters and the valid bits that make
//  unwritten matrix and plane entries read as zero; no clearing pass.
//  The input is taken in idle even while a result beat still waits in the output register.
//
module view_frustum_culler_core #(
    parameter int FRACTION_BITS = vfc_pkg::FRACTION_BITS_DEF,
    parameter int COUNTER_WIDTH = vfc_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vfc_in_if.sink    i_in,
    vfc_out_if.source o_out
);
    localparam int NUM_W = 32 + FRACTION_BITS;      // divide numerator width
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int SUM_W = 67;                      // three 64-bit products plus d term
    localparam int MA_W  = $clog2(vfc_pkg::MATRIX_DEPTH);
    localparam int PA_W  = $clog2(vfc_pkg::NUM_PLANES);

    vfc_pkg::t_state r_state, n_state;

    logic                      in_acc, out_go;
    logic                      m_we;
    logic [MA_W-1:0]           m_waddr, m_raddr;
    logic [31:0]               m_rdata, m_data;
    logic                      p_we;
    logic [PA_W-1:0]           p_raddr;
    logic [vfc_pkg::PLANE_W-1:0] p_rdata, p_data;

    logic [vfc_pkg::MATRIX_DEPTH-1:0] r_mvalid;
    logic [vfc_pkg::NUM_PLANES-1:0]   r_pvalid;
    logic                      r_m_rdv, r_p_rdv;
    logic [CNT_W-1:0]          r_cnt;
    logic [PA_W-1:0]           r_plane;
    logic [1:0]                r_comp;

    // apply datapath
    logic signed [31:0]        r_hold;
    logic signed [31:0]        r_v [4];            // rotating plane coefficients
    logic signed [32:0]        rowsum;
    logic signed [63:0]        r_sq;
    logic [63:0]               r_sumsq, r_rad;
    logic [34:0]               r_rem, rem_t, trial;
    logic [31:0]               r_root;
    logic [NUM_W-1:0]          r_num;
    logic                      r_neg;
    logic [31:0]               r_drem;
    logic [32:0]               drem_t;
    logic                      dge;
    logic [31:0]               vabs, qsat;
    logic [vfc_pkg::PLANE_W-1:0] r_pl;

    // test datapath
    logic [2:0]                r_kind;
    logic signed [31:0]        r_px, r_py, r_pz, r_qx, r_qy, r_qz;
    logic signed [SUM_W-1:0]   r_lim, plane_sum;
    logic                      r_s1, r_s1last, r_s2, r_s2last, r_tdone;
    logic signed [63:0]        r_m0, r_m1, r_m2;
    logic signed [31:0]        r_dd, sel_x, sel_y, sel_z;
    logic                      r_vis;

    logic [COUNTER_WIDTH-1:0]  r_vcnt, r_ccnt, n_vcnt, n_ccnt;
    logic                      r_ovalid;

    assign in_acc = i_in.valid && i_in.ready;
    assign out_go = (r_state == vfc_pkg::S_RESP) && (!r_ovalid || o_out.ready);

    vfc_ram #(.WIDTH(32), .DEPTH(vfc_pkg::MATRIX_DEPTH)) u_matrix_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (i_in.matrix_value),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    vfc_ram #(.WIDTH(vfc_pkg::PLANE_W), .DEPTH(vfc_pkg::NUM_PLANES)) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (r_plane),
        .i_wdata (r_pl),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vfc_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_in.kind) inside
                        vfc_pkg::KIND_APPLY: n_state = vfc_pkg::S_MREAD;
                        vfc_pkg::KIND_POINT, vfc_pkg::KIND_SPHERE, vfc_pkg::KIND_BOX:
                            n_state = vfc_pkg::S_TEST;
                        default: n_state = vfc_pkg::S_RESP;
                    endcase
                end
            end
            vfc_pkg::S_MREAD:  if (r_cnt == CNT_W'(8)) n_state = vfc_pkg::S_SQ;
            vfc_pkg::S_SQ:     if (r_cnt == CNT_W'(3)) n_state = vfc_pkg::S_SQRT;
            vfc_pkg::S_SQRT:   if (r_cnt == CNT_W'(31)) n_state = vfc_pkg::S_DLOAD;
            vfc_pkg::S_DLOAD:  n_state = vfc_pkg::S_DIV;
            vfc_pkg::S_DIV:    if (r_cnt == CNT_W'(NUM_W - 1)) n_state = vfc_pkg::S_DSTORE;
            vfc_pkg::S_DSTORE: begin
                n_state = (r_comp == 2'd3) ? vfc_pkg::S_PWRITE : vfc_pkg::S_DLOAD;
            end
            vfc_pkg::S_PWRITE: begin
                n_state = (r_plane == PA_W'(vfc_pkg::NUM_PLANES - 1)) ?
                          vfc_pkg::S_RESP : vfc_pkg::S_MREAD;
            end
            vfc_pkg::S_TEST:   if (r_tdone) n_state = vfc_pkg::S_RESP;
            vfc_pkg::S_RESP:   if (out_go) n_state = vfc_pkg::S_IDLE;
            default:           n_state = vfc_pkg::S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        i_in.ready = (r_state == vfc_pkg::S_IDLE);
        m_we       = in_acc && (i_in.kind == vfc_pkg::KIND_WRITE);
        m_waddr    = {i_in.matrix_col, i_in.matrix_row};
        // even steps read row 3 of column i, odd steps the plane's own row
        m_raddr    = {r_cnt[2:1], (r_cnt[0] ? r_plane[2:1] : 2'd3)};
        p_we       = (r_state == vfc_pkg::S_PWRITE);
        p_raddr    = r_cnt[PA_W-1:0];
    end

    assign m_data = r_m_rdv ? m_rdata : '0;
    assign p_data = r_p_rdv ? p_rdata : '0;

    // row sum or difference, then floor half
    assign rowsum = r_plane[0] ? ({r_hold[31], r_hold} - {m_data[31], m_data})
                               : ({r_hold[31], r_hold} + {m_data[31], m_data});

    // one square-root step: two radicand bits in, one root bit out
    assign rem_t = {r_rem[32:0], r_rad[63:62]};
    assign trial = {1'b0, r_root, 2'b01};

    // one restoring divide step
    assign drem_t = {r_drem, r_num[NUM_W-1]};
    assign dge    = drem_t >= {1'b0, r_root};
    assign vabs   = r_v[0][31] ? 32'(-r_v[0]) : 32'(r_v[0]);

    // sign and clamp the quotient magnitude; zero-length plane stores zeros
    always_comb begin
        if (r_root == '0) begin
            qsat = '0;
        end else if (r_neg) begin
            qsat = (r_num >= NUM_W'(64'h8000_0000)) ? 32'h8000_0000 : 32'(-r_num);
        end else begin
            qsat = (r_num > NUM_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r_num[31:0];
        end
    end

    // positive vertex for boxes, the point itself otherwise
    always_comb begin
        sel_x = r_px;
        sel_y = r_py;
        sel_z = r_pz;
        if (r_kind == vfc_pkg::KIND_BOX) begin
            if (!p_data[31])  sel_x = r_qx;
            if (!p_data[63])  sel_y = r_qy;
            if (!p_data[95])  sel_z = r_qz;
        end
    end

    assign plane_sum = SUM_W'(r_m0) + SUM_W'(r_m1) + SUM_W'(r_m2)
                     + (SUM_W'(r_dd) <<< FRACTION_BITS);

    // saturating counters bumped by sphere and box results
    always_comb begin
        n_vcnt = r_vcnt;
        n_ccnt = r_ccnt;
        if (r_kind == vfc_pkg::KIND_SPHERE || r_kind == vfc_pkg::KIND_BOX) begin
            if (r_vis) begin
                if (r_vcnt != '1) n_vcnt = r_vcnt + 1'b1;
            end else begin
                if (r_ccnt != '1) n_ccnt = r_ccnt + 1'b1;
            end
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vfc_pkg::S_IDLE;
            r_mvalid <= '0;
            r_pvalid <= '0;
            r_vcnt   <= '0;
            r_ccnt   <= '0;
            r_ovalid <= 1'b0;
            r_s1     <= 1'b0;
            r_s1last <= 1'b0;
            r_s2     <= 1'b0;
            r_s2last <= 1'b0;
            r_tdone  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? '0 : r_cnt + 1'b1;
            if (m_we) r_mvalid[m_waddr] <= 1'b1;
            if (p_we) r_pvalid[r_plane] <= 1'b1;
            if (p_we && r_plane == PA_W'(vfc_pkg::NUM_PLANES - 1)) begin
                r_vcnt <= '0;
                r_ccnt <= '0;
            end else if (out_go) begin
                r_vcnt <= n_vcnt;
                r_ccnt <= n_ccnt;
            end
            if (out_go) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
            // plane read pipeline for shape tests
            r_s1     <= (r_state == vfc_pkg::S_TEST) && (r_cnt < CNT_W'(vfc_pkg::NUM_PLANES));
            r_s1last <= (r_state == vfc_pkg::S_TEST) &&
                        (r_cnt == CNT_W'(vfc_pkg::NUM_PLANES - 1));
            r_s2     <= r_s1;
            r_s2last <= r_s1last;
            if (in_acc) r_tdone <= 1'b0;
            else if (r_s2last) r_tdone <= 1'b1;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        r_m_rdv <= r_mvalid[m_raddr];
        r_p_rdv <= (p_raddr < PA_W'(vfc_pkg::NUM_PLANES)) ? r_pvalid[p_raddr] : 1'b0;

        if (in_acc) begin
            r_kind  <= i_in.kind;
            r_px    <= i_in.px;
            r_py    <= i_in.py;
            r_pz    <= i_in.pz;
            r_qx    <= i_in.qx;
            r_qy    <= i_in.qy;
            r_qz    <= i_in.qz;
            r_lim   <= (i_in.kind == vfc_pkg::KIND_SPHERE) ?
                       -(SUM_W'($signed({1'b0, i_in.radius})) <<< FRACTION_BITS) : '0;
            r_vis   <= (i_in.kind == vfc_pkg::KIND_POINT) ||
                       (i_in.kind == vfc_pkg::KIND_SPHERE) ||
                       (i_in.kind == vfc_pkg::KIND_BOX);
            r_plane <= '0;
        end

        unique case (r_state)
            vfc_pkg::S_MREAD: begin
                r_sumsq <= '0;
                if (r_cnt[0]) begin
                    r_hold <= m_data;
                end else if (r_cnt != '0) begin
                    r_v[3] <= rowsum[32:1];
                    r_v[0] <= r_v[1];
                    r_v[1] <= r_v[2];
                    r_v[2] <= r_v[3];
                end
            end
            vfc_pkg::S_SQ: begin
                r_sq   <= r_v[0] * r_v[0];
                r_v[0] <= r_v[1];
                r_v[1] <= r_v[2];
                r_v[2] <= r_v[3];
                r_v[3] <= r_v[0];
                if (r_cnt != '0) r_sumsq <= r_sumsq + 64'(r_sq);
                if (r_cnt == CNT_W'(3)) begin
                    r_rad  <= r_sumsq + 64'(r_sq);
                    r_rem  <= '0;
                    r_root <= '0;
                end
            end
            vfc_pkg::S_SQRT: begin
                r_comp <= '0;
                r_rad  <= {r_rad[61:0], 2'b00};
                if (rem_t >= trial) begin
                    r_rem  <= rem_t - trial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= rem_t;
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            vfc_pkg::S_DLOAD: begin
                r_num  <= {vabs, {FRACTION_BITS{1'b0}}};
                r_neg  <= r_v[0][31];
                r_drem <= '0;
                r_v[0] <= r_v[1];
                r_v[1] <= r_v[2];
                r_v[2] <= r_v[3];
                r_v[3] <= r_v[0];
            end
            vfc_pkg::S_DIV: begin
                r_drem <= dge ? 32'(drem_t - {1'b0, r_root}) : drem_t[31:0];
                r_num  <= {r_num[NUM_W-2:0], dge};
            end
            vfc_pkg::S_DSTORE: begin
                r_pl   <= {qsat, r_pl[vfc_pkg::PLANE_W-1:32]};
                r_comp <= r_comp + 1'b1;
            end
            vfc_pkg::S_PWRITE: begin
                r_plane <= r_plane + 1'b1;
            end
            default: begin
            end
        endcase

        // shape test: stage 1 multiplies, stage 2 sums and compares
        if (r_s1) begin
            r_m0 <= $signed(p_data[31:0])  * sel_x;
            r_m1 <= $signed(p_data[63:32]) * sel_y;
            r_m2 <= $signed(p_data[95:64]) * sel_z;
            r_dd <= p_data[127:96];
        end
        if (r_s2 && (plane_sum < r_lim)) r_vis <= 1'b0;

        if (out_go) begin
            o_out.visible       <= r_vis;
            o_out.visible_total <= 32'(n_vcnt);
            o_out.culled_total  <= 32'(n_ccnt);
        end
    end

    assign o_out.valid = r_ovalid;

    // ---------------- assertions ----------------
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != vfc_pkg::S_IDLE)
        else $error("accepted beat left sequencer idle");

    a_no_plane_write_in_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vfc_pkg::S_TEST) |-> !p_we && !m_we)
        else $error("store written during shape test");

    a_counters_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != vfc_pkg::S_RESP && r_state != vfc_pkg::S_PWRITE)
        |=> $stable(r_vcnt) && $stable(r_ccnt))
        else $error("counter moved outside result or apply");

    a_result_only_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_ovalid && !out_go) |=> !r_ovalid)
        else $error("result beat appeared without a finished item");
endmodule
`default_nettype wire

[tb/view_frustum_culler_core_test.sv]
// Testbench: directed and random checks of the frustum culler against a fixed-point predictor.
`timescale 1ns / 100ps
`default_nettype none
module view_frustum_culler_core_test;

    localparam int FB = vfc_pkg::FRACTION_BITS_DEF;
    localparam longint CNT_MAX = (64'd1 << vfc_pkg::COUNTER_WIDTH_DEF) - 1;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic        visible;
        logic [31:0] visible_total;
        logic [31:0] culled_total;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    vfc_in_if  item_ch ();
    vfc_out_if result_ch ();

    view_frustum_culler_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_ch.sink),
        .o_out   (result_ch.source)
    );

    // predictor state
    longint  mat_q [16];
    longint  plane_q [24];
    longint  vis_cnt;
    longint  cull_cnt;
    t_result expected_q [$];
    int      errors;
    longint  cycles;
    int      hold_off;     // long receiver stall, counted in the receiver process
    bit      offering;     // input valid is currently driven high

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // floor square root of a non-negative 64-bit value
    function automatic longint isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    // rebuild the six normalized planes from the matrix store
    task automatic extract_planes();
        longint v [4];
        longint unsigned sumsq;
        longint len;
        longint q;
        int     row;
        for (int p = 0; p < vfc_pkg::NUM_PLANES; p++) begin
            row = p >> 1;
            for (int i = 0; i < 4; i++) begin
                v[i] = (p & 1) ? mat_q[i*4+3] - mat_q[i*4+row]
                               : mat_q[i*4+3] + mat_q[i*4+row];
                v[i] = v[i] >>> 1;
            end
            sumsq = 0;
            for (int i = 0; i < 3; i++) sumsq += longint'(v[i] * v[i]);
            len = isqrt(sumsq);
            for (int i = 0; i < 4; i++) begin
                q = 0;
                if (len != 0) q = (v[i] * (longint'(1) << FB)) / len;
                if (q > 64'sh7FFFFFFF) q = 64'sh7FFFFFFF;
                if (q < -64'sh80000000) q = -64'sh80000000;
                plane_q[p*4+i] = q;
            end
        end
        vis_cnt = 0;
        cull_cnt = 0;
    endtask

    function automatic longint plane_dist(int p, longint x, longint y, longint z);
        return plane_q[p*4] * x + plane_q[p*4+1] * y + plane_q[p*4+2] * z
             + plane_q[p*4+3] * (longint'(1) << FB);
    endfunction

    task automatic bump(bit vis);
        if (vis) begin
            if (vis_cnt < CNT_MAX) vis_cnt++;
        end else begin
            if (cull_cnt < CNT_MAX) cull_cnt++;
        end
    endtask

    // predict the result beat of one accepted item
    task automatic predict_cull(input logic [2:0] kind, input logic [1:0] col,
                                input logic [1:0] row, input logic signed [31:0] mval,
                                input logic signed [31:0] pv [3],
                                input logic signed [31:0] qv [3],
                                input logic [30:0] rad);
        bit      vis;
        longint  lim;
        longint  c [3];
        t_result r;
        vis = 1'b0;
        case (kind) inside
            vfc_pkg::KIND_WRITE: mat_q[{col, row}] = longint'(mval);
            vfc_pkg::KIND_APPLY: extract_planes();
            vfc_pkg::KIND_POINT, vfc_pkg::KIND_SPHERE: begin
                lim = (kind == vfc_pkg::KIND_SPHERE) ?
                      -(longint'(rad) * (longint'(1) << FB)) : 64'sd0;
                vis = 1'b1;
                for (int p = 0; p < vfc_pkg::NUM_PLANES; p++)
                    if (plane_dist(p, pv[0], pv[1], pv[2]) < lim) vis = 1'b0;
                if (kind == vfc_pkg::KIND_SPHERE) bump(vis);
            end
            vfc_pkg::KIND_BOX: begin
                vis = 1'b1;
                for (int p = 0; p < vfc_pkg::NUM_PLANES; p++) begin
                    // positive vertex: max where the normal component is non-negative
                    for (int a = 0; a < 3; a++)
                        c[a] = (plane_q[p*4+a] >= 0) ? longint'(qv[a]) : longint'(pv[a]);
                    if (plane_dist(p, c[0], c[1], c[2]) < 0) vis = 1'b0;
                end
                bump(vis);
            end
            default: ;
        endcase
        r.visible = vis;
        r.visible_total = vis_cnt[31:0];
        r.culled_total = cull_cnt[31:0];
        expected_q.push_back(r);
    endtask

    // send one beat, with a random gap before it
    task automatic send_item(input logic [2:0] kind, input logic [1:0] col,
                             input logic [1:0] row, input logic signed [31:0] mval,
                             input logic signed [31:0] pv [3],
                             input logic signed [31:0] qv [3],
                             input logic [30:0] rad, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
        if (gap > 0 && offering) begin
            item_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        repeat (gap) @(posedge i_clk);
        item_ch.valid        <= 1'b1;
        offering = 1'b1;
        item_ch.kind         <= kind;
        item_ch.matrix_col   <= col;
        item_ch.matrix_row   <= row;
        item_ch.matrix_value <= mval;
        item_ch.px <= pv[0]; item_ch.py <= pv[1]; item_ch.pz <= pv[2];
        item_ch.qx <= qv[0]; item_ch.qy <= qv[1]; item_ch.qz <= qv[2];
        item_ch.radius       <= rad;
        do @(posedge i_clk); while (!item_ch.ready);
        predict_cull(kind, col, row, mval, pv, qv, rad);
    endtask

    // result checker and random receiver stalls
    initial begin
        t_result got;
        t_result exp_r;
        int      stall;
        result_ch.ready <= 1'b0;
        stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (result_ch.valid && result_ch.ready) begin
                got = '{result_ch.visible, result_ch.visible_total, result_ch.culled_total};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected beat %p", $realtime, got);
                    errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.visible !== exp_r.visible)
                        $display("%0t: visible exp %0d got %0d", $realtime, exp_r.visible, got.visible);
                    if (got.visible_total !== exp_r.visible_total)
                        $display("%0t: visible_total exp %0d got %0d", $realtime,
                                 exp_r.visible_total, got.visible_total);
                    if (got.culled_total !== exp_r.culled_total)
                        $display("%0t: culled_total exp %0d got %0d", $realtime,
                                 exp_r.culled_total, got.culled_total);
                    if (got !== exp_r) errors++;
                end
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end
            if (hold_off > 0) begin
                hold_off--;
                result_ch.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return ($urandom_range(0, 1)) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h00140000)) - 32'sh000A0000;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 0;
            default: return $signed($urandom_range(0, 32'h00040000)) - 32'sh00020000;
        endcase
    endfunction

    task automatic wait_drained();
        if (offering) begin
            item_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_elem(int c, int r, logic signed [31:0] v, bit no_gap = 0);
        logic signed [31:0] z [3];
        z = '{0, 0, 0};
        send_item(vfc_pkg::KIND_WRITE, c[1:0], r[1:0], v, z, z, '0, no_gap);
    endtask

    task automatic apply_matrix_item();
        logic signed [31:0] z [3];
        z = '{0, 0, 0};
        send_item(vfc_pkg::KIND_APPLY, 2'($urandom()), 2'($urandom()), $urandom(), z, z,
                  31'($urandom()));
    endtask

    task automatic random_shape(bit no_gap = 0);
        logic signed [31:0] pv [3];
        logic signed [31:0] qv [3];
        logic [2:0] k;
        logic [30:0] rad;
        for (int a = 0; a < 3; a++) begin
            pv[a] = rand_coord();
            qv[a] = ($urandom_range(0, 4) == 0) ? rand_coord()
                  : pv[a] + $signed({1'b0, 15'd0, 16'($urandom())}) * $urandom_range(0, 16);
        end
        rad = ($urandom_range(0, 4) == 0) ? 31'($urandom())
                                          : 31'($urandom_range(0, 32'h00080000));
        k = 3'(vfc_pkg::KIND_POINT + $urandom_range(0, 2));
        if ($urandom_range(0, 30) == 0) k = 3'($urandom_range(5, 7));
        send_item(k, 2'($urandom()), 2'($urandom()), $urandom(), pv, qv, rad, no_gap);
    endtask

    // load a perspective-like matrix with random perturbation, or pure noise
    task automatic load_matrix(bit noisy);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                write_elem(c, r, noisy ? rand_elem()
                    : ((c == r && c < 3) ? 32'sh00010000 : 0)
                      + ((c == 2 && r == 3) ? -32'sh00010000 : 0)
                      + ((c == 3 && r == 2) ? -32'sh00008000 : 0)
                      + $signed($urandom_range(0, 32'h2000)) - 32'sh1000);
    endtask

    task automatic test_directed();
        logic signed [31:0] z [3];
        logic signed [31:0] hi [3];
        logic signed [31:0] lo [3];
        z = '{0, 0, 0};
        hi = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
        lo = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        // zero planes: everything touches
        send_item(vfc_pkg::KIND_POINT, '0, '0, '0, lo, hi, '0);
        send_item(vfc_pkg::KIND_SPHERE, '0, '0, '0, hi, lo, 31'h7FFFFFFF);
        send_item(vfc_pkg::KIND_BOX, '0, '0, '0, hi, lo, '0);
        send_item(3'd7, 2'd3, 2'd3, 32'sh80000000, z, z, '0);
        write_elem(0, 0, 32'sh7FFFFFFF);
        write_elem(3, 3, 32'sh80000000);
        write_elem(0, 3, 32'sh80000000);
        write_elem(3, 0, 32'sh7FFFFFFF);
        apply_matrix_item();
        send_item(vfc_pkg::KIND_POINT, '0, '0, '0, hi, z, '0);
        send_item(vfc_pkg::KIND_BOX, '0, '0, '0, lo, hi, '0);
        send_item(vfc_pkg::KIND_BOX, '0, '0, '0, hi, lo, '0);   // min above max
        send_item(vfc_pkg::KIND_SPHERE, '0, '0, '0, lo, z, 31'h7FFFFFFF);
        send_item(vfc_pkg::KIND_SPHERE, '0, '0, '0, z, z, '0);
        load_matrix(0);
        apply_matrix_item();
        for (int i = 0; i < 6; i++) random_shape();
        wait_drained();
    endtask

    task automatic test_random();
        for (int n = 0; n < 45; n++) begin
            load_matrix(n % 5 == 4);
            apply_matrix_item();
            repeat (14) random_shape();
        end
    endtask

    // receiver holds off while the sender keeps going, then sender pauses until drained
    task automatic test_backpressure();
        hold_off = 300;
        repeat (20) random_shape(1);
        wait_drained();
        repeat (10) random_shape();
        wait_drained();
    endtask

    initial begin
        errors = 0;
        hold_off = 0;
        offering = 1'b0;
        vis_cnt = 0;
        cull_cnt = 0;
        foreach (mat_q[i]) mat_q[i] = 0;
        foreach (plane_q[i]) plane_q[i] = 0;
        item_ch.valid <= 1'b0;
        item_ch.kind <= vfc_pkg::KIND_WRITE;
        item_ch.matrix_col <= '0; item_ch.matrix_row <= '0; item_ch.matrix_value <= '0;
        item_ch.px <= '0; item_ch.py <= '0; item_ch.pz <= '0;
        item_ch.qx <= '0; item_ch.qy <= '0; item_ch.qz <= '0;
        item_ch.radius <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
rtl/core/vfc_pkg.sv
rtl/core/vfc_if.sv
rtl/core/vfc_ram.sv
rtl/core/view_frustum_culler_core.sv
tb/view_frustum_culler_core_test.sv
